// ===== src/hcc_pkg.sv =====
// shared types and constants for the hilbert curve index codec
package hcc_pkg;

    localparam int COORD_W = 16;
    localparam int INDEX_W = 48;
    localparam int DIM_W   = 2;
    localparam int NB_W    = 5;
    localparam int CFG_W   = 5;

    // operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // configuration register indexes
    localparam logic CFG_DIMENSIONS = 1'b0;
    localparam logic CFG_ORDER_BITS = 1'b1;

    localparam logic [DIM_W-1:0] DIMENSIONS_RST = 2'd2;
    localparam logic [DIM_W-1:0] DIMENSIONS_3D  = 2'd3;
    localparam logic [NB_W-1:0]  ORDER_BITS_RST = 5'd16;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic [INDEX_W-1:0] curve_index;
    } t_in_req;

    typedef struct packed {
        logic [INDEX_W-1:0] result_index;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_z;
    } t_out_req;

    // per-item control that travels down the pipeline
    typedef struct packed {
        logic            op;
        logic            n3;
        logic [NB_W-1:0] nb;
    } t_ctrl;

endpackage

// ===== src/hilbert_curve_index_codec.sv =====
// top level of the hilbert curve index codec: config registers and stage chain
//
// Converts 2-D or 3-D grid coordinates to a Hilbert curve index (operation 0)
// or an index back to coordinates (operation 1), using the transpose method.
// Input requests arrive on i_valid/o_ready with a t_in_req payload; results
// leave on o_valid/i_ready as t_out_req, one result per request, in order.
// Two registers are written through i_cfg_we/i_cfg_idx/i_cfg_data: dimensions
// (2 or 3 axes) and order_bits (bits per axis, clamped to 1..AXIS_BITS).
// Write them only while no request is in flight.
// The pipeline has one input stage (masking, or de-interleave
// and gray decode), one stage per curve level for AXIS_BITS - 1 levels, and one
// output stage (gray encode, correction and interleave). A new request is
// taken every cycle while the receiver is not stalling. Each stage has its own valid bit and a stage loads
// whenever it is empty or its successor moves, so a stalled receiver fills
// the bubbles first and then holds o_ready low; nothing is lost or repeated.
// Reset clears all valid bits and sets dimensions to 2 and order_bits to 16.
module hilbert_curve_index_codec
    import hcc_pkg::*;
#(
    parameter int AXIS_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_req          i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_req         o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = AXIS_BITS;
    localparam int NL = AXIS_BITS - 1;

    logic [DIM_W-1:0] r_dimensions;
    logic [NB_W-1:0]  r_order_bits;
    t_ctrl            in_ctrl;

    logic            st_valid [0:NL];
    logic            st_ready [0:NL];
    t_ctrl           st_ctrl  [0:NL];
    logic [3*AW-1:0] st_x     [0:NL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimensions <= DIMENSIONS_RST;
            r_order_bits <= ORDER_BITS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIMENSIONS: r_dimensions <= i_cfg_data[DIM_W-1:0];
                CFG_ORDER_BITS: r_order_bits <= i_cfg_data[NB_W-1:0];
                default:        r_order_bits <= r_order_bits;
            endcase
        end
    end

    always_comb begin
        in_ctrl.op = i_req.operation;
        in_ctrl.n3 = (r_dimensions == DIMENSIONS_3D);
        if (r_order_bits == '0) begin
            in_ctrl.nb = NB_W'(1);
        end else if (r_order_bits > NB_W'(AXIS_BITS)) begin
            in_ctrl.nb = NB_W'(AXIS_BITS);
        end else begin
            in_ctrl.nb = r_order_bits;
        end
    end

    hcc_front #(
        .AW (AW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .i_ctrl  (in_ctrl),
        .o_valid (st_valid[0]),
        .i_ready (st_ready[0]),
        .o_ctrl  (st_ctrl[0]),
        .o_x     (st_x[0])
    );

    // encode walks the levels top down, decode bottom up
    for (genvar j = 0; j < NL; j++) begin : g_level
        hcc_level #(
            .AW    (AW),
            .B_ENC (AW - 1 - j),
            .B_DEC (j + 1)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[j]),
            .o_ready (st_ready[j]),
            .i_ctrl  (st_ctrl[j]),
            .i_x     (st_x[j]),
            .o_valid (st_valid[j+1]),
            .i_ready (st_ready[j+1]),
            .o_ctrl  (st_ctrl[j+1]),
            .o_x     (st_x[j+1])
        );
    end

    hcc_back #(
        .AW (AW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[NL]),
        .o_ready (st_ready[NL]),
        .i_ctrl  (st_ctrl[NL]),
        .i_x     (st_x[NL]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

endmodule

// ===== src/hcc_front.sv =====
// first stage: coordinate masking for encode, de-interleave and gray decode for decode
module hcc_front
    import hcc_pkg::*;
#(
    parameter int AW = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_in_req         i_req,
    input  t_ctrl           i_ctrl,
    output logic            o_valid,
    input  logic            i_ready,
    output t_ctrl           o_ctrl,
    output logic [3*AW-1:0] o_x
);

    logic                    r_valid;
    t_ctrl                   r_ctrl;
    logic [3*AW-1:0]         r_x;
    logic [3*AW-1:0]         n_x;
    logic [AW-1:0]           mask;
    logic [AW-1:0]           d0, d1, d2;
    logic [AW-1:0]           g0, g1, g2;
    logic [3*AW+INDEX_W-1:0] idx_ext;

    assign o_ready = !r_valid || i_ready;
    assign idx_ext = (3*AW+INDEX_W)'(i_req.curve_index);

    always_comb begin
        mask = '0;
        d0   = '0;
        d1   = '0;
        d2   = '0;
        for (int b = 0; b < AW; b++) begin
            mask[b] = NB_W'(b) < i_ctrl.nb;
            if (mask[b]) begin
                if (i_ctrl.n3) begin
                    d0[b] = idx_ext[3*b+2];
                    d1[b] = idx_ext[3*b+1];
                    d2[b] = idx_ext[3*b];
                end else begin
                    d0[b] = idx_ext[2*b+1];
                    d1[b] = idx_ext[2*b];
                end
            end
        end
        // gray decode uses the values before this step
        if (i_ctrl.n3) begin
            g2 = d2 ^ d1;
            g1 = d1 ^ d0;
            g0 = d0 ^ (d2 >> 1);
        end else begin
            g2 = '0;
            g1 = d1 ^ d0;
            g0 = d0 ^ (d1 >> 1);
        end
        if (i_req.operation == OP_ENCODE) begin
            n_x = {(i_ctrl.n3 ? (AW'(i_req.coord_z) & mask) : AW'(0)),
                   AW'(i_req.coord_y) & mask,
                   AW'(i_req.coord_x) & mask};
        end else begin
            n_x = {g2, g1, g0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl <= i_ctrl;
            r_x    <= n_x;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_x     = r_x;

endmodule

// ===== src/hcc_level.sv =====
// one curve level: conditional low-bit inversion or swap across the axes
module hcc_level
    import hcc_pkg::*;
#(
    parameter int AW    = 16,
    parameter int B_ENC = 15,
    parameter int B_DEC = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_ctrl           i_ctrl,
    input  logic [3*AW-1:0] i_x,
    output logic            o_valid,
    input  logic            i_ready,
    output t_ctrl           o_ctrl,
    output logic [3*AW-1:0] o_x
);

    localparam logic [AW-1:0] P_ENC = AW'((64'd1 << B_ENC) - 64'd1);
    localparam logic [AW-1:0] P_DEC = AW'((64'd1 << B_DEC) - 64'd1);

    logic            r_valid;
    t_ctrl           r_ctrl;
    logic [3*AW-1:0] r_x;
    logic [AW-1:0]   x0, x1, x2;
    logic [AW-1:0]   sw;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        x0 = i_x[AW-1:0];
        x1 = i_x[2*AW-1:AW];
        x2 = i_x[3*AW-1:2*AW];
        sw = '0;
        if (i_ctrl.op == OP_ENCODE) begin
            if (NB_W'(B_ENC) < i_ctrl.nb) begin
                // axes in ascending order
                if (x0[B_ENC]) x0 = x0 ^ P_ENC;
                if (x1[B_ENC]) begin
                    x0 = x0 ^ P_ENC;
                end else begin
                    sw = (x0 ^ x1) & P_ENC;
                    x0 = x0 ^ sw;
                    x1 = x1 ^ sw;
                end
                if (i_ctrl.n3) begin
                    if (x2[B_ENC]) begin
                        x0 = x0 ^ P_ENC;
                    end else begin
                        sw = (x0 ^ x2) & P_ENC;
                        x0 = x0 ^ sw;
                        x2 = x2 ^ sw;
                    end
                end
            end
        end else begin
            if (NB_W'(B_DEC) < i_ctrl.nb) begin
                // axes in descending order
                if (i_ctrl.n3) begin
                    if (x2[B_DEC]) begin
                        x0 = x0 ^ P_DEC;
                    end else begin
                        sw = (x0 ^ x2) & P_DEC;
                        x0 = x0 ^ sw;
                        x2 = x2 ^ sw;
                    end
                end
                if (x1[B_DEC]) begin
                    x0 = x0 ^ P_DEC;
                end else begin
                    sw = (x0 ^ x1) & P_DEC;
                    x0 = x0 ^ sw;
                    x1 = x1 ^ sw;
                end
                if (x0[B_DEC]) x0 = x0 ^ P_DEC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl <= i_ctrl;
            r_x    <= {x2, x1, x0};
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_x     = r_x;

endmodule

// ===== src/hcc_back.sv =====
// last stage: gray encode with correction and interleave, or coordinate output
module hcc_back
    import hcc_pkg::*;
#(
    parameter int AW = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_ctrl           i_ctrl,
    input  logic [3*AW-1:0] i_x,
    output logic            o_valid,
    input  logic            i_ready,
    output t_out_req        o_res
);

    logic            r_valid;
    t_out_req        r_res;
    t_out_req        n_res;
    logic [AW-1:0]   x0, x1, x2;
    logic [AW-1:0]   g0, g1, g2;
    logic [AW-1:0]   last;
    logic [AW-1:0]   corr;
    logic [3*AW-1:0] ilv;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        x0 = i_x[AW-1:0];
        x1 = i_x[2*AW-1:AW];
        x2 = i_x[3*AW-1:2*AW];
        g0 = x0;
        g1 = x1 ^ x0;
        g2 = x2 ^ g1;
        last = i_ctrl.n3 ? g2 : g1;
        // each bit of the correction is the parity of the last axis above it
        corr = '0;
        for (int j = AW - 2; j >= 0; j--) begin
            corr[j] = ^(last >> (j + 1));
        end
        g0 = g0 ^ corr;
        g1 = g1 ^ corr;
        g2 = g2 ^ corr;
        ilv = '0;
        for (int b = 0; b < AW; b++) begin
            if (i_ctrl.n3) begin
                ilv[3*b+2] = g0[b];
                ilv[3*b+1] = g1[b];
                ilv[3*b]   = g2[b];
            end else begin
                ilv[2*b+1] = g0[b];
                ilv[2*b]   = g1[b];
            end
        end
        n_res = '0;
        if (i_ctrl.op == OP_ENCODE) begin
            n_res.result_index = INDEX_W'(ilv);
        end else begin
            n_res.out_x = COORD_W'(x0);
            n_res.out_y = COORD_W'(x1);
            n_res.out_z = i_ctrl.n3 ? COORD_W'(x2) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== tb/hilbert_curve_index_checker.sv =====
// checker for the hilbert curve index codec: predicts each result and compares it
`timescale 1ns / 1ps
module hilbert_curve_index_checker
    import hcc_pkg::*;
#(
    parameter int AXIS_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  t_in_req          i_req,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  t_out_req         i_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_failures,
    output int               o_outstanding
);

    typedef logic [2:0][COORD_W-1:0] t_axes;

    logic [DIM_W-1:0] dims_reg;
    logic [NB_W-1:0]  order_reg;
    t_out_req         expected_results [$];

    function automatic t_axes exchange_low(input t_axes axes, input int a,
                                           input logic [COORD_W-1:0] low);
        logic [COORD_W-1:0] diff;
        diff = (axes[0] ^ axes[a]) & low;
        axes[0] = axes[0] ^ diff;
        axes[a] = axes[a] ^ diff;
        return axes;
    endfunction

    function automatic logic [INDEX_W-1:0] hilbert_encode(input t_axes start, input int n,
                                                          input int levels);
        t_axes              axes;
        logic [COORD_W-1:0] low;
        logic [COORD_W-1:0] correction;
        logic [INDEX_W-1:0] index;
        axes = start;
        correction = '0;
        index = '0;
        // top level first: invert or exchange the low bits of the first axis
        for (int b = levels - 1; b >= 1; b--) begin
            low = COORD_W'((32'd1 << b) - 32'd1);
            for (int a = 0; a < n; a++) begin
                if (axes[a][b]) begin
                    axes[0] = axes[0] ^ low;
                end else begin
                    axes = exchange_low(axes, a, low);
                end
            end
        end
        for (int a = 1; a < n; a++) axes[a] = axes[a] ^ axes[a-1];
        for (int b = levels - 1; b >= 1; b--) begin
            if (axes[n-1][b]) correction = correction ^ COORD_W'((32'd1 << b) - 32'd1);
        end
        for (int a = 0; a < n; a++) axes[a] = axes[a] ^ correction;
        // first axis lands in the top bit of each group
        for (int b = 0; b < levels; b++) begin
            for (int a = 0; a < n; a++) index[b*n + n - 1 - a] = axes[a][b];
        end
        return index;
    endfunction

    function automatic t_axes hilbert_decode(input logic [INDEX_W-1:0] index, input int n,
                                             input int levels);
        t_axes              axes;
        logic [COORD_W-1:0] low;
        logic [COORD_W-1:0] shifted;
        axes = '0;
        for (int b = 0; b < levels; b++) begin
            for (int a = 0; a < n; a++) axes[a][b] = index[b*n + n - 1 - a];
        end
        // gray decode
        shifted = axes[n-1] >> 1;
        for (int a = n - 1; a >= 1; a--) axes[a] = axes[a] ^ axes[a-1];
        axes[0] = axes[0] ^ shifted;
        // bottom level up, last axis first
        for (int b = 1; b < levels; b++) begin
            low = COORD_W'((32'd1 << b) - 32'd1);
            for (int a = n - 1; a >= 0; a--) begin
                if (axes[a][b]) begin
                    axes[0] = axes[0] ^ low;
                end else begin
                    axes = exchange_low(axes, a, low);
                end
            end
        end
        return axes;
    endfunction

    function automatic t_out_req predict_result(input t_in_req req);
        t_out_req           res;
        t_axes              axes;
        logic [COORD_W-1:0] mask;
        int                 n;
        int                 levels;
        res = '0;
        n = (dims_reg == DIMENSIONS_3D) ? 3 : 2;
        // order is clamped to 1..AXIS_BITS
        levels = int'(order_reg);
        if (levels < 1) levels = 1;
        if (levels > AXIS_BITS) levels = AXIS_BITS;
        mask = COORD_W'((32'd1 << levels) - 32'd1);
        if (req.operation == OP_ENCODE) begin
            axes = '0;
            axes[0] = req.coord_x & mask;
            axes[1] = req.coord_y & mask;
            if (n == 3) axes[2] = req.coord_z & mask;
            res.result_index = hilbert_encode(axes, n, levels);
        end else begin
            axes = hilbert_decode(req.curve_index, n, levels);
            res.out_x = axes[0];
            res.out_y = axes[1];
            res.out_z = (n == 3) ? axes[2] : '0;
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [INDEX_W-1:0] want,
                                 input logic [INDEX_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            o_failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            dims_reg = DIMENSIONS_RST;
            order_reg = ORDER_BITS_RST;
            expected_results.delete();
            o_failures = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DIMENSIONS) begin
                    dims_reg = i_cfg_data[DIM_W-1:0];
                end else begin
                    order_reg = i_cfg_data[NB_W-1:0];
                end
            end
            if (i_req_valid && i_req_ready) expected_results.push_back(predict_result(i_req));
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result %0h with no request outstanding", i_res);
                    o_failures++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("result_index", want.result_index, i_res.result_index);
                    compare_field("out_x", want.out_x, i_res.out_x);
                    compare_field("out_y", want.out_y, i_res.out_y);
                    compare_field("out_z", want.out_z, i_res.out_z);
                end
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

// ===== tb/hilbert_curve_index_codec_test.sv =====
// testbench top for the hilbert curve index codec: stimulus, stalls and verdict
`timescale 1ns / 1ps
module hilbert_curve_index_codec_test;
    import hcc_pkg::*;

    localparam int AXIS_BITS            = 16;
    localparam int REQUESTS_PER_SETTING = 160;
    localparam int SETTING_COUNT        = 12;
    localparam int DRAIN_CYCLES         = 2 * (AXIS_BITS + 1) + 8;
    localparam int CYCLE_LIMIT          = 500000;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_LONG_STALLS,
        RX_TOGGLE
    } t_rx_mode;

    typedef struct packed {
        logic [CFG_W-1:0] dims_data;
        logic [CFG_W-1:0] order_data;
    } t_setting;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_ready;
    t_in_req          i_req      = '0;
    logic             o_valid;
    logic             i_ready    = 1'b0;
    t_out_req         o_res;
    logic             i_cfg_we   = 1'b0;
    logic             i_cfg_idx  = CFG_DIMENSIONS;
    logic [CFG_W-1:0] i_cfg_data = '0;

    int       failures;
    int       outstanding;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    t_rx_mode rx_mode      = RX_STEADY;
    int       rx_mode_left = 0;
    int       rx_run_left  = 0;

    hilbert_curve_index_codec #(
        .AXIS_BITS (AXIS_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    hilbert_curve_index_checker #(
        .AXIS_BITS (AXIS_BITS)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req         (i_req),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_res         (o_res),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: the stall pattern is changed at random among the four modes
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_mode_left <= 300;
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        if (rx_run_left != 0) begin
            rx_run_left <= rx_run_left - 1;
        end else begin
            case (rx_mode)
                RX_STEADY: begin
                    i_ready <= 1'b1;
                    rx_run_left <= 7;
                end
                RX_RANDOM: begin
                    i_ready <= ($urandom_range(0, 9) < 7);
                    rx_run_left <= 0;
                end
                RX_LONG_STALLS: begin
                    if (i_ready) begin
                        i_ready <= 1'b0;
                        rx_run_left <= $urandom_range(0, 19);
                    end else begin
                        i_ready <= 1'b1;
                        rx_run_left <= $urandom_range(0, 7);
                    end
                end
                default: begin
                    i_ready <= !i_ready;
                    rx_run_left <= $urandom_range(0, 1);
                end
            endcase
        end
    end

    // all zeros, all ones, or random bits
    function automatic logic [INDEX_W-1:0] biased_bits();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return INDEX_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic t_in_req random_request();
        t_in_req req;
        req.operation   = $urandom_range(0, 1) ? OP_DECODE : OP_ENCODE;
        req.coord_x     = COORD_W'(biased_bits());
        req.coord_y     = COORD_W'(biased_bits());
        req.coord_z     = COORD_W'(biased_bits());
        req.curve_index = biased_bits();
        return req;
    endfunction

    // unused index field carries noise so that it is seen to be ignored
    function automatic t_in_req encode_req(input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic [COORD_W-1:0] z);
        t_in_req req;
        req.operation   = OP_ENCODE;
        req.coord_x     = x;
        req.coord_y     = y;
        req.coord_z     = z;
        req.curve_index = INDEX_W'({$urandom, $urandom});
        return req;
    endfunction

    function automatic t_in_req decode_req(input logic [INDEX_W-1:0] index);
        t_in_req req;
        req.operation   = OP_DECODE;
        req.coord_x     = COORD_W'($urandom);
        req.coord_y     = COORD_W'($urandom);
        req.coord_z     = COORD_W'($urandom);
        req.curve_index = index;
        return req;
    endfunction

    task automatic send_request(input t_in_req req);
        int gap;
        i_valid <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 40);
            i_valid <= 1'b0;
            i_req <= random_request();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_settings(input t_setting setting);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DIMENSIONS;
        i_cfg_data <= setting.dims_data;
        @(posedge i_clk);
        i_cfg_idx <= CFG_ORDER_BITS;
        i_cfg_data <= setting.order_data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_setting plan;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 2-D at full order straight after reset; z and high index bits are ignored
        send_request(encode_req(16'h0000, 16'h0000, 16'h0000));
        send_request(encode_req(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(encode_req(16'hFFFF, 16'h0000, 16'h0000));
        send_request(encode_req(16'h0000, 16'hFFFF, 16'h1234));
        send_request(encode_req(16'hAAAA, 16'h5555, 16'hFFFF));
        send_request(encode_req(16'h0001, 16'h0000, 16'h0000));
        send_request(encode_req(16'h8000, 16'h8000, 16'h0000));
        send_request(decode_req(48'h0000_0000_0000));
        send_request(decode_req(48'hFFFF_FFFF_FFFF));
        send_request(decode_req(48'h0000_FFFF_FFFF));
        send_request(decode_req(48'h0000_0000_0001));
        send_request(decode_req(48'h0000_8000_0000));
        send_request(decode_req(48'hAAAA_AAAA_AAAA));
        wait_idle();

        write_settings('{CFG_W'(DIMENSIONS_3D), CFG_W'(ORDER_BITS_RST)});
        send_request(encode_req(16'h0000, 16'h0000, 16'h0000));
        send_request(encode_req(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(encode_req(16'h0000, 16'h0000, 16'hFFFF));
        send_request(encode_req(16'h0001, 16'h0002, 16'h0004));
        send_request(decode_req(48'h0000_0000_0000));
        send_request(decode_req(48'hFFFF_FFFF_FFFF));
        send_request(decode_req(48'h8000_0000_0000));
        send_request(decode_req(48'h5555_5555_5555));
        send_request(decode_req(48'h0000_0000_0001));

        // dimension values 0, 1 and upper data bits fall back to 2-D or mask to 3;
        // order 0 acts as 1 and anything above the axis width as full width
        for (int k = 0; k < SETTING_COUNT; k++) begin
            case (k)
                0:       plan = '{5'd2,  5'd16};
                1:       plan = '{5'd3,  5'd16};
                2:       plan = '{5'd31, 5'd1};
                3:       plan = '{5'd0,  5'd0};
                4:       plan = '{5'd1,  5'd31};
                5:       plan = '{5'd30, 5'd17};
                6:       plan = '{5'd3,  5'd2};
                7:       plan = '{5'd2,  5'd5};
                8:       plan = '{5'd7,  5'd11};
                9:       plan = '{5'd2,  5'd8};
                10:      plan = '{5'd3,  5'd15};
                default: plan = '{5'd2,  5'd3};
            endcase
            wait_idle();
            write_settings(plan);
            repeat (REQUESTS_PER_SETTING) send_request(random_request());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
